/* hdl/rgbca_pkg.sv */
// Shared types, constants and helpers for the RGB555 color adjust pipeline.
package rgbca_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_COEFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_COEFS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_COEFS = 3'd5;

  localparam int unsigned MODE_CC = 0;
  localparam int unsigned MODE_BLEND = 1;
  localparam int unsigned MODE_YIQ = 2;

  localparam logic [2:0] RST_MODE = 3'd0;
  localparam logic [8:0] RST_CONTRAST = 9'd256;
  localparam logic [11:0] RST_BRIGHTNESS = 12'd0;
  localparam logic [31:0] RST_RED_COEFS = 32'd166727500;
  localparam logic [31:0] RST_GREEN_COEFS = 32'd4121361318;
  localparam logic [31:0] RST_BLUE_COEFS = 32'd456912466;

  localparam logic [7:0] CC_CAP = 8'd240;

  // stages inside the converter, plus the blend/output register
  localparam int unsigned CONV_STAGES = 5;
  localparam int unsigned PIPE_STAGES = CONV_STAGES + 1;

  typedef struct packed {
    logic [2:0]       mode;
    logic [8:0]       contrast_gain;
    logic [11:0]      brightness_offset;
    logic [2:0][31:0] coefs;
  } cfg_t;

  typedef struct packed {
    logic [14:0] prev_pixel;
    logic [14:0] pixel;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [7:0] cap240(input logic [7:0] v);
    return (v > CC_CAP) ? CC_CAP : v;
  endfunction

endpackage

/* hdl/rgbca_conv.sv */
// One-pixel converter: widen or color-correct, YIQ transform, gain/offset, coefficient mix, clamp.
module rgbca_conv (
  input  logic                  clk,
  input  logic                  en,
  input  rgbca_pkg::cfg_t       cfg,
  input  logic [14:0]           pixel,
  output logic [2:0][7:0]       chan
);

  localparam logic signed [21:0] Y_R = 22'sd1225;
  localparam logic signed [21:0] Y_G = 22'sd2404;
  localparam logic signed [21:0] Y_B = 22'sd467;
  localparam logic signed [21:0] I_R = 22'sd2441;
  localparam logic signed [21:0] I_G = 22'sd1126;
  localparam logic signed [21:0] I_B = 22'sd1315;
  localparam logic signed [21:0] Q_R = 22'sd868;
  localparam logic signed [21:0] Q_G = 22'sd2142;
  localparam logic signed [21:0] Q_B = 22'sd1274;

  logic [4:0] r5, g5, b5;
  logic [9:0] mr, mg, mb;
  logic [2:0][7:0] s1_ch_next;

  logic [2:0][7:0] s1_ch;
  logic signed [21:0] ri, gi, bi;
  logic signed [21:0] yv, iv, qv;

  logic [20:0] s2_y;
  logic signed [21:0] s2_i, s2_q;
  logic [2:0][7:0] s2_ch;

  logic [29:0] s3_yg;
  logic signed [37:0] s3_pi [3];
  logic signed [37:0] s3_pq [3];
  logic [2:0][7:0] s3_ch;

  logic signed [39:0] yterm, oterm;
  logic signed [39:0] s4_sum [3];
  logic [2:0][7:0] s4_ch;

  logic [2:0][7:0] s5_next;

  // stage 1: widen to eight bits, or in CC mode color-correct and cap at 240
  always_comb begin
    r5 = pixel[4:0];
    g5 = pixel[9:5];
    b5 = pixel[14:10];
    mr = {5'b0, r5} * 10'd26 + {5'b0, g5} * 10'd4 + {5'b0, b5} * 10'd2;
    mg = {5'b0, g5} * 10'd24 + {5'b0, b5} * 10'd8;
    mb = {5'b0, r5} * 10'd6 + {5'b0, g5} * 10'd4 + {5'b0, b5} * 10'd22;
    if (cfg.mode[rgbca_pkg::MODE_CC]) begin
      s1_ch_next[0] = rgbca_pkg::cap240(mr[9:2]);
      s1_ch_next[1] = rgbca_pkg::cap240(mg[9:2]);
      s1_ch_next[2] = rgbca_pkg::cap240(mb[9:2]);
    end else begin
      s1_ch_next[0] = rgbca_pkg::widen5(r5);
      s1_ch_next[1] = rgbca_pkg::widen5(g5);
      s1_ch_next[2] = rgbca_pkg::widen5(b5);
    end
  end

  // stage 2: YIQ in Q.12
  always_comb begin
    ri = signed'({14'b0, s1_ch[0]});
    gi = signed'({14'b0, s1_ch[1]});
    bi = signed'({14'b0, s1_ch[2]});
    yv = Y_R * ri + Y_G * gi + Y_B * bi;
    iv = I_R * ri - I_G * gi - I_B * bi;
    qv = Q_R * ri - Q_G * gi + Q_B * bi;
  end

  // stage 4 operands: luma term and offset in Q.24
  always_comb begin
    yterm = signed'({6'b0, s3_yg, 4'b0});
    oterm = 40'(signed'(cfg.brightness_offset)) <<< 20;
  end

  // stage 5: clamp, or pass the stage 1 value when the adjust is off
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!cfg.mode[rgbca_pkg::MODE_YIQ]) begin
        s5_next[k] = s4_ch[k];
      end else if (s4_sum[k][39]) begin
        s5_next[k] = 8'd0;
      end else if (s4_sum[k][38:32] != 7'd0) begin
        s5_next[k] = 8'hFF;
      end else begin
        s5_next[k] = s4_sum[k][31:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ch <= s1_ch_next;

      s2_y  <= yv[20:0];
      s2_i  <= iv;
      s2_q  <= qv;
      s2_ch <= s1_ch;

      s3_yg <= {9'b0, s2_y} * {21'b0, cfg.contrast_gain};
      for (int k = 0; k < 3; k++) begin
        s3_pi[k] <= 38'(signed'(cfg.coefs[k][15:0])) * 38'(s2_i);
        s3_pq[k] <= 38'(signed'(cfg.coefs[k][31:16])) * 38'(s2_q);
      end
      s3_ch <= s2_ch;

      for (int k = 0; k < 3; k++) begin
        s4_sum[k] <= yterm + oterm + 40'(s3_pi[k]) + 40'(s3_pq[k]);
      end
      s4_ch <= s3_ch;

      chan <= s5_next;
    end
  end

endmodule

/* hdl/rgb555_color_adjust_pipeline_top.sv */
// Top level of the RGB555 color adjust pipeline: config, valid pipe, blend, output.
//
//   channel  signals                          direction  payload
//   in       in_valid, in_stall, in_data      into block pix_in_t (pixel, prev_pixel)
//   out      out_valid, out_stall, out_data   out of     pix_out_t (red, green, blue)
//   cfg      cfg_write, cfg_index, cfg_data   into block register write, no read-back
//
// One transaction per cycle while the output is not stalled; data passes five converter
// stages, then the blend/output register.
// Every stage advances together; a stalled output holds the whole pipe and
// raises in_stall in the same cycle.
// Synchronous reset clears the valid bits and loads the register defaults.
module rgb555_color_adjust_pipeline_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  rgbca_pkg::pix_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rgbca_pkg::pix_out_t                    out_data,
  input  logic                                   cfg_write,
  input  logic [rgbca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rgbca_pkg::CFG_DATA_W-1:0]       cfg_data
);

  rgbca_pkg::cfg_t cfg;
  logic en;
  logic [rgbca_pkg::PIPE_STAGES-1:0] vld;
  logic [2:0][7:0] cur_ch, prv_ch;
  logic [2:0][7:0] blend_ch;
  logic [8:0] pair_sum [3];
  rgbca_pkg::pix_out_t out_next;

  assign en        = !(vld[rgbca_pkg::PIPE_STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[rgbca_pkg::PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= rgbca_pkg::RST_MODE;
      cfg.contrast_gain     <= rgbca_pkg::RST_CONTRAST;
      cfg.brightness_offset <= rgbca_pkg::RST_BRIGHTNESS;
      cfg.coefs[0]          <= rgbca_pkg::RST_RED_COEFS;
      cfg.coefs[1]          <= rgbca_pkg::RST_GREEN_COEFS;
      cfg.coefs[2]          <= rgbca_pkg::RST_BLUE_COEFS;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbca_pkg::REG_MODE:        cfg.mode              <= cfg_data[2:0];
        rgbca_pkg::REG_CONTRAST:    cfg.contrast_gain     <= cfg_data[8:0];
        rgbca_pkg::REG_BRIGHTNESS:  cfg.brightness_offset <= cfg_data[11:0];
        rgbca_pkg::REG_RED_COEFS:   cfg.coefs[0]          <= cfg_data;
        rgbca_pkg::REG_GREEN_COEFS: cfg.coefs[1]          <= cfg_data;
        rgbca_pkg::REG_BLUE_COEFS:  cfg.coefs[2]          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[rgbca_pkg::PIPE_STAGES-2:0], in_valid};
    end
  end

  rgbca_conv u_conv_cur (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .pixel (in_data.pixel),
    .chan  (cur_ch)
  );

  rgbca_conv u_conv_prev (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .pixel (in_data.prev_pixel),
    .chan  (prv_ch)
  );

  // floor average with the previous frame in blend mode, else the current pixel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pair_sum[k] = {1'b0, cur_ch[k]} + {1'b0, prv_ch[k]};
      blend_ch[k] = cfg.mode[rgbca_pkg::MODE_BLEND] ? pair_sum[k][8:1] : cur_ch[k];
    end
    out_next.red   = blend_ch[0];
    out_next.green = blend_ch[1];
    out_next.blue  = blend_ch[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (rst)
    vld[rgbca_pkg::PIPE_STAGES-2] && !in_stall |=> out_valid)
    else $error("transaction lost between last stages");

  a_replicate_pattern: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.mode == rgbca_pkg::RST_MODE |->
      out_data.red[2:0] == out_data.red[7:5] && out_data.blue[2:0] == out_data.blue[7:5])
    else $error("bit replication broken");

endmodule
